// ===== sv/bqeq_pkg.sv =====
// Shared constants, widths and codes of the biquad cascade equalizer.
package bqeq_pkg;

	localparam int NUM_BANDS      = 6;
	localparam int COEF_FRAC_BITS = 20;
	localparam int SAMPLE_BITS    = 32;
	localparam int COEF_BITS      = 24;
	localparam int COEFS_PER_BAND = 5;
	localparam int BANK_SIZE      = 2 * NUM_BANDS;
	localparam int MASK_BITS      = 2 * NUM_BANDS;
	localparam int COEF_DEPTH     = BANK_SIZE * COEFS_PER_BAND;

	localparam int ACTION_BITS = 2;
	localparam int BAND_BITS   = 3;
	localparam int SEL_BITS    = 3;

	localparam int IDX_BITS  = $clog2(BANK_SIZE);
	localparam int SLOT_BITS = $clog2(COEF_DEPTH);

	// Digit-serial multiply: coefficient consumed DIGIT_BITS per cycle
	localparam int DIGIT_BITS = 8;
	localparam int NUM_DIGITS = (COEF_BITS + DIGIT_BITS - 1) / DIGIT_BITS;
	localparam int DIG_BITS   = (NUM_DIGITS > 1) ? $clog2(NUM_DIGITS) : 1;
	localparam int SHIFT_BITS = $clog2(NUM_DIGITS * DIGIT_BITS);
	localparam int PP_BITS    = SAMPLE_BITS + DIGIT_BITS + 1;
	localparam int ACC_BITS   = SAMPLE_BITS + COEF_BITS + $clog2(COEFS_PER_BAND);
	localparam int RSH_BITS   = ACC_BITS - COEF_FRAC_BITS;

	localparam logic signed [ACC_BITS-1:0] RND_HALF =
		ACC_BITS'(1) << (COEF_FRAC_BITS - 1);
	localparam logic signed [RSH_BITS-1:0] RSH_MAX =
		{{(RSH_BITS-SAMPLE_BITS+1){1'b0}}, {(SAMPLE_BITS-1){1'b1}}};
	localparam logic signed [RSH_BITS-1:0] RSH_MIN =
		{{(RSH_BITS-SAMPLE_BITS+1){1'b1}}, {(SAMPLE_BITS-1){1'b0}}};
	localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
	localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

	typedef enum logic [ACTION_BITS-1:0] {
		ACT_FILTER = 2'd0,
		ACT_WRITE  = 2'd1,
		ACT_CLEAR  = 2'd2,
		ACT_NONE   = 2'd3
	} action_t;

	// Coefficient selects
	localparam logic [SEL_BITS-1:0] SEL_A0 = 3'd0;
	localparam logic [SEL_BITS-1:0] SEL_A1 = 3'd1;
	localparam logic [SEL_BITS-1:0] SEL_A2 = 3'd2;
	localparam logic [SEL_BITS-1:0] SEL_B1 = 3'd3;
	localparam logic [SEL_BITS-1:0] SEL_B2 = 3'd4;

endpackage

// ===== sv/bqeq_if.sv =====
// Valid/ready channel interfaces for equalizer items and results.
interface bqeq_item_if;
	import bqeq_pkg::*;

	logic                          valid;
	logic                          ready;
	logic [ACTION_BITS-1:0]        action;
	logic                          channel;
	logic [BAND_BITS-1:0]          band;
	logic [SEL_BITS-1:0]           coef_select;
	logic signed [COEF_BITS-1:0]   coef_value;
	logic signed [SAMPLE_BITS-1:0] sample_in;

	modport source (
		output valid, action, channel, band, coef_select, coef_value, sample_in,
		input  ready
	);
	modport sink (
		input  valid, action, channel, band, coef_select, coef_value, sample_in,
		output ready
	);
endinterface

interface bqeq_result_if;
	import bqeq_pkg::*;

	logic                          valid;
	logic                          ready;
	logic                          channel_out;
	logic signed [SAMPLE_BITS-1:0] sample_out;
	logic                          saturated;

	modport source (
		output valid, channel_out, sample_out, saturated,
		input  ready
	);
	modport sink (
		input  valid, channel_out, sample_out, saturated,
		output ready
	);
endinterface

// ===== sv/biquad_cascade_equalizer_unit.sv =====
// Two-bank cascaded biquad equalizer with a digit-serial shared multiply-accumulate.
//
//  channel    dir  handshake            beat carries
//  ---------  ---  -------------------  ---------------------------------------------
//  item       in   valid/ready          action, channel, band, coef_select,
//                                       coef_value, sample_in
//  result     out  valid/ready          channel_out, sample_out, saturated
//  cfg        in   cfg_we (no ready)    cfg_wdata -> band_enable_mask
//
//  One item at a time: item.ready is high only in IDLE. A filter beat walks the six bands:
//  each active band runs five products through the shared multiplier,
//  each product being one coefficient fetch, one load and three 8-bit digit steps, then
//  a drain and a round/saturate step. A coefficient write adds a compare step; a clear does not.
//  Reset clears the mask, all histories and the coefficient valid bits at once; no sweep.
//  A finished sample waits in the result register, so the next item is taken while the
//  sink stalls; only a second finished sample waits for the register to drain.
module biquad_cascade_equalizer_unit (
	input  logic                            clk,
	input  logic                            arst_n,
	bqeq_item_if.sink                       item,
	bqeq_result_if.source                   result,
	input  logic                            cfg_we,
	input  logic [bqeq_pkg::MASK_BITS-1:0]  cfg_wdata
);
	import bqeq_pkg::*;

	typedef enum logic [8:0] {
		S_IDLE   = 9'b000000001,
		S_WR_CMP = 9'b000000010,
		S_BAND   = 9'b000000100,
		S_FETCH  = 9'b000001000,
		S_LOAD   = 9'b000010000,
		S_DIGIT  = 9'b000100000,
		S_DRAIN  = 9'b001000000,
		S_ROUND  = 9'b010000000,
		S_EMIT   = 9'b100000000
	} state_t;

	state_t state_q;

	// Band enable register
	logic [MASK_BITS-1:0] mask_q;

	// Coefficient memory and its valid bits (an unwritten entry reads as zero)
	logic [COEF_BITS-1:0]  coef_mem [COEF_DEPTH];
	logic [COEF_DEPTH-1:0] coef_vld_q;
	logic [COEF_BITS-1:0]  rdata_q;
	logic                  rvld_q;
	logic                  rd_en;
	logic [SLOT_BITS-1:0]  rd_addr;
	logic                  mem_we;

	// Filter histories, one entry per band and channel
	logic signed [SAMPLE_BITS-1:0] xh1_q [BANK_SIZE];
	logic signed [SAMPLE_BITS-1:0] xh2_q [BANK_SIZE];
	logic signed [SAMPLE_BITS-1:0] yh1_q [BANK_SIZE];
	logic signed [SAMPLE_BITS-1:0] yh2_q [BANK_SIZE];

	// Item context
	logic                          ch_q;
	logic [BAND_BITS-1:0]          band_q;
	logic [SEL_BITS-1:0]           k_q;
	logic [DIG_BITS-1:0]           dig_q;
	logic signed [SAMPLE_BITS-1:0] x_q;
	logic                          sat_q;
	logic [IDX_BITS-1:0]           wr_idx_q;
	logic [SLOT_BITS-1:0]          wr_slot_q;
	logic signed [COEF_BITS-1:0]   wr_val_q;

	// Multiply-accumulate datapath
	logic [COEF_BITS-1:0]          coef_sr_q;
	logic signed [SAMPLE_BITS-1:0] op_q;
	logic signed [ACC_BITS-1:0]    pp_s1;
	logic                          pp_vld_s1;
	logic signed [ACC_BITS-1:0]    acc_q;

	// Result register
	logic                          out_vld_q;
	logic                          out_ch_q;
	logic signed [SAMPLE_BITS-1:0] out_sample_q;
	logic                          out_sat_q;

	logic                 item_acc;
	action_t              item_action;
	logic                 item_wr_ok;
	logic [IDX_BITS-1:0]  item_idx;
	logic [SLOT_BITS-1:0] item_slot;
	logic [IDX_BITS-1:0]  cur_idx;
	logic [SLOT_BITS-1:0] cur_slot;
	logic                 last_band;
	logic                 last_digit;
	logic                 last_coef;
	logic                 out_free;
	logic [COEF_BITS-1:0] cur_coef;
	logic                 coef_change;

	logic signed [SAMPLE_BITS-1:0] op_mux;
	logic signed [DIGIT_BITS:0]    digit_s;
	logic signed [PP_BITS-1:0]     prod;
	logic [SHIFT_BITS-1:0]         shamt;
	logic signed [ACC_BITS-1:0]    biased;
	logic signed [RSH_BITS-1:0]    rsh;
	logic                          clip_hi;
	logic                          clip_lo;
	logic signed [SAMPLE_BITS-1:0] y_rnd;

	assign item.ready   = (state_q == S_IDLE);
	assign item_acc     = item.valid && item.ready;
	assign item_action  = action_t'(item.action);
	assign item_wr_ok   = (item.band < BAND_BITS'(NUM_BANDS))
	                   && (item.coef_select < SEL_BITS'(COEFS_PER_BAND));
	assign item_idx     = IDX_BITS'(item.channel) * IDX_BITS'(NUM_BANDS)
	                    + IDX_BITS'(item.band);
	assign item_slot    = SLOT_BITS'(item_idx) * SLOT_BITS'(COEFS_PER_BAND)
	                    + SLOT_BITS'(item.coef_select);

	assign cur_idx      = IDX_BITS'(ch_q) * IDX_BITS'(NUM_BANDS) + IDX_BITS'(band_q);
	assign cur_slot     = SLOT_BITS'(cur_idx) * SLOT_BITS'(COEFS_PER_BAND)
	                    + SLOT_BITS'(k_q);
	assign last_band    = (band_q == BAND_BITS'(NUM_BANDS - 1));
	assign last_digit   = (dig_q == DIG_BITS'(NUM_DIGITS - 1));
	assign last_coef    = (k_q == SEL_B2);
	assign out_free     = !out_vld_q || result.ready;

	// Memory read: the write compare in IDLE, the coefficient fetch in FETCH
	assign rd_en   = (item_acc && (item_action == ACT_WRITE) && item_wr_ok)
	              || (state_q == S_FETCH);
	assign rd_addr = (state_q == S_IDLE) ? item_slot : cur_slot;

	assign cur_coef    = rvld_q ? rdata_q : '0;
	assign coef_change = (cur_coef != wr_val_q);
	assign mem_we      = (state_q == S_WR_CMP) && coef_change;

	always_ff @(posedge clk) begin
		if (mem_we) begin
			coef_mem[wr_slot_q] <= wr_val_q;
		end
		if (rd_en) begin
			rdata_q <= coef_mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_vld_q <= '0;
			rvld_q     <= 1'b0;
		end else begin
			if (mem_we) begin
				coef_vld_q[wr_slot_q] <= 1'b1;
			end
			if (rd_en) begin
				rvld_q <= coef_vld_q[rd_addr];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_q <= '0;
		end else if (cfg_we) begin
			mask_q <= cfg_wdata;
		end
	end

	// Operand for the product in flight: the band input or one history tap
	always_comb begin
		unique case (k_q)
			SEL_A0:  op_mux = x_q;
			SEL_A1:  op_mux = xh1_q[cur_idx];
			SEL_A2:  op_mux = xh2_q[cur_idx];
			SEL_B1:  op_mux = yh1_q[cur_idx];
			default: op_mux = yh2_q[cur_idx];
		endcase
	end

	// Low digits are unsigned, the top digit carries the coefficient sign
	assign digit_s = last_digit
		? {coef_sr_q[DIGIT_BITS-1], coef_sr_q[DIGIT_BITS-1:0]}
		: {1'b0, coef_sr_q[DIGIT_BITS-1:0]};
	assign prod    = op_q * digit_s;
	assign shamt   = SHIFT_BITS'(dig_q) * SHIFT_BITS'(DIGIT_BITS);

	// Round half up, then clamp to the sample range
	assign biased  = acc_q + RND_HALF;
	assign rsh     = biased[ACC_BITS-1:COEF_FRAC_BITS];
	assign clip_hi = (rsh > RSH_MAX);
	assign clip_lo = (rsh < RSH_MIN);
	assign y_rnd   = clip_hi ? SAMPLE_MAX
	               : clip_lo ? SAMPLE_MIN
	               : rsh[SAMPLE_BITS-1:0];

	// Partial product stage and accumulator
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pp_vld_s1 <= 1'b0;
		end else begin
			pp_vld_s1 <= (state_q == S_DIGIT);
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_DIGIT) begin
			pp_s1     <= ACC_BITS'(prod) <<< shamt;
			coef_sr_q <= coef_sr_q >> DIGIT_BITS;
		end else if (state_q == S_LOAD) begin
			coef_sr_q <= cur_coef;
			op_q      <= op_mux;
		end
		if ((state_q == S_LOAD) && (k_q == SEL_A0)) begin
			acc_q <= '0;
		end else if (pp_vld_s1) begin
			acc_q <= acc_q + pp_s1;
		end
	end

	// Item context registers (payload, no reset)
	always_ff @(posedge clk) begin
		if (item_acc) begin
			ch_q      <= item.channel;
			x_q       <= item.sample_in;
			wr_idx_q  <= item_idx;
			wr_slot_q <= item_slot;
			wr_val_q  <= item.coef_value;
		end else if (state_q == S_ROUND) begin
			x_q <= y_rnd;
		end
	end

	// Histories: clear all, clear one band on a changed coefficient, or advance
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < BANK_SIZE; i++) begin
				xh1_q[i] <= '0;
				xh2_q[i] <= '0;
				yh1_q[i] <= '0;
				yh2_q[i] <= '0;
			end
		end else begin
			if (item_acc && (item_action == ACT_CLEAR)) begin
				for (int i = 0; i < BANK_SIZE; i++) begin
					xh1_q[i] <= '0;
					xh2_q[i] <= '0;
					yh1_q[i] <= '0;
					yh2_q[i] <= '0;
				end
			end else if (mem_we) begin
				xh1_q[wr_idx_q] <= '0;
				xh2_q[wr_idx_q] <= '0;
				yh1_q[wr_idx_q] <= '0;
				yh2_q[wr_idx_q] <= '0;
			end else if (state_q == S_ROUND) begin
				xh2_q[cur_idx] <= xh1_q[cur_idx];
				xh1_q[cur_idx] <= x_q;
				yh2_q[cur_idx] <= yh1_q[cur_idx];
				yh1_q[cur_idx] <= y_rnd;
			end
		end
	end

	// Sequencer: walk the bands, five products per active band, digit by digit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			band_q  <= '0;
			k_q     <= '0;
			dig_q   <= '0;
			sat_q   <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (item_acc) begin
						priority if (item_action == ACT_FILTER) begin
							band_q  <= '0;
							sat_q   <= 1'b0;
							state_q <= S_BAND;
						end else if ((item_action == ACT_WRITE) && item_wr_ok) begin
							state_q <= S_WR_CMP;
						end else begin
							state_q <= S_IDLE;
						end
					end
				end
				S_WR_CMP: begin
					state_q <= S_IDLE;
				end
				S_BAND: begin
					if (mask_q[cur_idx]) begin
						k_q     <= SEL_A0;
						state_q <= S_FETCH;
					end else if (last_band) begin
						state_q <= S_EMIT;
					end else begin
						band_q <= band_q + BAND_BITS'(1);
					end
				end
				S_FETCH: begin
					state_q <= S_LOAD;
				end
				S_LOAD: begin
					dig_q   <= '0;
					state_q <= S_DIGIT;
				end
				S_DIGIT: begin
					dig_q <= dig_q + DIG_BITS'(1);
					if (last_digit) begin
						if (last_coef) begin
							state_q <= S_DRAIN;
						end else begin
							k_q     <= k_q + SEL_BITS'(1);
							state_q <= S_FETCH;
						end
					end
				end
				S_DRAIN: begin
					state_q <= S_ROUND;
				end
				S_ROUND: begin
					sat_q <= sat_q | clip_hi | clip_lo;
					if (last_band) begin
						state_q <= S_EMIT;
					end else begin
						band_q  <= band_q + BAND_BITS'(1);
						state_q <= S_BAND;
					end
				end
				S_EMIT: begin
					// hold until the result register is free
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Result register: load from EMIT, drop on a taken beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if ((state_q == S_EMIT) && out_free) begin
			out_vld_q <= 1'b1;
		end else if (result.ready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == S_EMIT) && out_free) begin
			out_ch_q     <= ch_q;
			out_sample_q <= x_q;
			out_sat_q    <= sat_q;
		end
	end

	assign result.valid       = out_vld_q;
	assign result.channel_out = out_ch_q;
	assign result.sample_out  = out_sample_q;
	assign result.saturated   = out_sat_q;

	// A finished sample always lands in the result register and frees the sequencer
	a_emit_loads: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_EMIT) && out_free |=> out_vld_q && (state_q == S_IDLE))
		else $error("finished sample not loaded into result register");

	// The last partial product is absorbed before rounding
	a_round_drained: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_ROUND) |-> !pp_vld_s1 && last_coef)
		else $error("rounding with a partial product still pending");

	// A changed coefficient leaves its band with zero history
	a_write_clears: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |=> (xh1_q[wr_idx_q] == '0) && (yh1_q[wr_idx_q] == '0)
		        && (xh2_q[wr_idx_q] == '0) && (yh2_q[wr_idx_q] == '0))
		else $error("band history not cleared after coefficient change");

	// Memory reads only happen while idle or fetching
	a_read_window: assert property (@(posedge clk) disable iff (!arst_n)
		rd_en |-> (state_q == S_IDLE) || (state_q == S_FETCH))
		else $error("coefficient read outside its window");

endmodule

// ===== tb/biquad_cascade_equalizer_unit_tb.sv =====
// Biquad cascade equalizer testbench: directed table, then random phases against a predictor.
module biquad_cascade_equalizer_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import bqeq_pkg::*;

	localparam int CLK_HALF     = 2;
	localparam int RESET_CYCLES = 5;
	// DRAIN_CYCLES covers the longest item, a filter beat with all six bands active.
	localparam int DRAIN_CYCLES = 200;
	localparam int CYCLE_LIMIT  = 1_500_000;
	localparam int NUM_PHASES   = 8;
	localparam int PHASE_ITEMS  = 219;

	localparam int COEF_ONE  = 1 << COEF_FRAC_BITS;
	localparam int COEF_HALF = 1 << (COEF_FRAC_BITS - 1);
	localparam int COEF_MAX  = (1 << (COEF_BITS - 1)) - 1;
	localparam int COEF_MIN  = -(1 << (COEF_BITS - 1));

	localparam logic CH_LEFT  = 1'b0;
	localparam logic CH_RIGHT = 1'b1;

	// Band and select codes past the end of the coefficient store
	localparam int BAND_PAST_END = NUM_BANDS;
	localparam int BAND_TOP      = (1 << BAND_BITS) - 1;
	localparam int SEL_PAST_END  = COEFS_PER_BAND;
	localparam int SEL_TOP       = (1 << SEL_BITS) - 1;

	localparam logic [MASK_BITS-1:0] MASK_NONE  = '0;
	localparam logic [MASK_BITS-1:0] MASK_ALL   = '1;
	localparam logic [MASK_BITS-1:0] MASK_LEFT  = MASK_BITS'((1 << NUM_BANDS) - 1);
	localparam logic [MASK_BITS-1:0] MASK_RIGHT = MASK_LEFT << NUM_BANDS;
	// First band of each bank only
	localparam logic [MASK_BITS-1:0] MASK_FIRST = MASK_BITS'(1) | (MASK_BITS'(1) << NUM_BANDS);

	// One stimulus row: an item beat, or a mask write when is_cfg is set (mask in smp).
	// has_lit marks rows whose output is typed in rather than predicted.
	typedef struct packed {
		logic                   is_cfg;
		action_t                act;
		logic                   ch;
		logic [BAND_BITS-1:0]   band;
		logic [SEL_BITS-1:0]    sel;
		logic [COEF_BITS-1:0]   coef;
		logic [SAMPLE_BITS-1:0] smp;
		logic                   has_lit;
		logic [SAMPLE_BITS-1:0] lit_smp;
		logic                   lit_sat;
	} eq_step_t;

	typedef struct packed {
		logic                   ch;
		logic [SAMPLE_BITS-1:0] smp;
		logic                   sat;
	} eq_out_t;

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_we;
	logic [MASK_BITS-1:0] cfg_wdata;

	bqeq_item_if   item_ch ();
	bqeq_result_if result_ch ();

	biquad_cascade_equalizer_unit uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.item      (item_ch),
		.result    (result_ch),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	// Shadow of the equalizer state, advanced on every accepted item beat
	logic signed [COEF_BITS-1:0]   coef_bank [COEF_DEPTH];
	logic signed [SAMPLE_BITS-1:0] x_hist1   [BANK_SIZE];
	logic signed [SAMPLE_BITS-1:0] x_hist2   [BANK_SIZE];
	logic signed [SAMPLE_BITS-1:0] y_hist1   [BANK_SIZE];
	logic signed [SAMPLE_BITS-1:0] y_hist2   [BANK_SIZE];
	logic [MASK_BITS-1:0]          band_mask;

	eq_out_t  pending_outputs [$];
	eq_step_t directed_rows [$];

	int errors    = 0;
	int idle_pct  = 0;
	int stall_pct = 0;

	initial begin
		clk = 1'b0;
		forever #CLK_HALF clk = ~clk;
	end

	initial begin : watchdog
		int cycles;
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("[biquad_cascade_equalizer_unit] ERROR");
		$finish;
	end

	// Result sink: hold ready low on stall_pct percent of cycles, drawn fresh each cycle.
	initial begin
		result_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			result_ch.ready <= ($urandom_range(99) >= stall_pct);
		end
	end

	// Compare every output beat with the oldest prediction.
	always @(posedge clk) begin : check_outputs
		eq_out_t want;
		if (arst_n === 1'b1 && result_ch.valid === 1'b1 && result_ch.ready === 1'b1) begin
			if (pending_outputs.size() == 0) begin
				$display("%0t: output beat with nothing expected: ch %0d sample %0d sat %0d",
					$time, result_ch.channel_out, result_ch.sample_out, result_ch.saturated);
				errors++;
			end else begin
				want = pending_outputs.pop_front();
				if (result_ch.channel_out !== want.ch) begin
					$display("%0t: channel_out expected %0d, got %0d",
						$time, want.ch, result_ch.channel_out);
					errors++;
				end
				if (result_ch.sample_out !== want.smp) begin
					$display("%0t: sample_out expected %0d, got %0d",
						$time, $signed(want.smp), result_ch.sample_out);
					errors++;
				end
				if (result_ch.saturated !== want.sat) begin
					$display("%0t: saturated expected %0d, got %0d",
						$time, want.sat, result_ch.saturated);
					errors++;
				end
			end
		end
	end

	task automatic clear_hist(input int idx);
		x_hist1[idx] = '0;
		x_hist2[idx] = '0;
		y_hist1[idx] = '0;
		y_hist2[idx] = '0;
	endtask

	// Advance the shadow state by one item; produced is set for a filter beat.
	task automatic equalize(input eq_step_t s, output logic produced, output eq_out_t o);
		longint x;
		longint acc;
		longint y;
		int     idx;
		int     slot;
		int     b;
		logic   sat;
		produced = 1'b0;
		o = '0;
		case (s.act)
		ACT_WRITE: begin
			// Out-of-range band or select: drop the write
			if (s.band < NUM_BANDS && s.sel < COEFS_PER_BAND) begin
				idx = (s.ch ? NUM_BANDS : 0) + s.band;
				slot = idx * COEFS_PER_BAND + s.sel;
				// A changed coefficient restarts the band from silence
				if (coef_bank[slot] != s.coef) begin
					coef_bank[slot] = s.coef;
					clear_hist(idx);
				end
			end
		end
		ACT_CLEAR: begin
			for (b = 0; b < BANK_SIZE; b++)
				clear_hist(b);
		end
		ACT_FILTER: begin
			x = longint'($signed(s.smp));
			sat = 1'b0;
			for (b = 0; b < NUM_BANDS; b++) begin
				idx = (s.ch ? NUM_BANDS : 0) + b;
				// Bypassed bands keep their history untouched
				if (band_mask[idx]) begin
					slot = idx * COEFS_PER_BAND;
					acc = longint'(coef_bank[slot + SEL_A0]) * x
						+ longint'(coef_bank[slot + SEL_A1]) * longint'(x_hist1[idx])
						+ longint'(coef_bank[slot + SEL_A2]) * longint'(x_hist2[idx])
						+ longint'(coef_bank[slot + SEL_B1]) * longint'(y_hist1[idx])
						+ longint'(coef_bank[slot + SEL_B2]) * longint'(y_hist2[idx]);
					// Round half toward plus infinity, then clip to the sample range
					y = (acc + longint'(COEF_HALF)) >>> COEF_FRAC_BITS;
					if (y > longint'(SAMPLE_MAX)) begin
						y = longint'(SAMPLE_MAX);
						sat = 1'b1;
					end else if (y < longint'(SAMPLE_MIN)) begin
						y = longint'(SAMPLE_MIN);
						sat = 1'b1;
					end
					x_hist2[idx] = x_hist1[idx];
					x_hist1[idx] = x[SAMPLE_BITS-1:0];
					y_hist2[idx] = y_hist1[idx];
					y_hist1[idx] = y[SAMPLE_BITS-1:0];
					x = y;
				end
			end
			o.ch = s.ch;
			o.smp = x[SAMPLE_BITS-1:0];
			o.sat = sat;
			produced = 1'b1;
		end
		default: begin
		end
		endcase
	endtask

	// Drop valid, wait for every predicted beat, then let a trailing write or clear finish.
	task automatic settle();
		@(negedge clk);
		item_ch.valid <= 1'b0;
		while (pending_outputs.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic load_mask(input logic [MASK_BITS-1:0] m);
		settle();
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= m;
		@(negedge clk);
		cfg_we <= 1'b0;
		band_mask = m;
	endtask

	task automatic send_step(input eq_step_t s);
		logic    produced;
		eq_out_t o;
		if (s.is_cfg) begin
			load_mask(s.smp[MASK_BITS-1:0]);
		end else begin
			@(negedge clk);
			// Idle the sender for a random number of cycles
			while ($urandom_range(99) < idle_pct) begin
				item_ch.valid <= 1'b0;
				@(negedge clk);
			end
			item_ch.valid <= 1'b1;
			item_ch.action <= s.act;
			item_ch.channel <= s.ch;
			item_ch.band <= s.band;
			item_ch.coef_select <= s.sel;
			item_ch.coef_value <= s.coef;
			item_ch.sample_in <= s.smp;
			do
				@(posedge clk);
			while (item_ch.ready !== 1'b1);
			equalize(s, produced, o);
			if (produced) begin
				if (s.has_lit) begin
					o.smp = s.lit_smp;
					o.sat = s.lit_sat;
				end
				pending_outputs.push_back(o);
			end
		end
	endtask

	function automatic eq_step_t row(input logic is_cfg, input action_t act, input logic ch,
		input int band, input int sel, input int coef, input int smp,
		input logic has_lit, input int lit_smp, input logic lit_sat);
		eq_step_t s;
		s.is_cfg = is_cfg;
		s.act = act;
		s.ch = ch;
		s.band = BAND_BITS'(band);
		s.sel = SEL_BITS'(sel);
		s.coef = COEF_BITS'(coef);
		s.smp = SAMPLE_BITS'(smp);
		s.has_lit = has_lit;
		s.lit_smp = SAMPLE_BITS'(lit_smp);
		s.lit_sat = lit_sat;
		return s;
	endfunction

	// Mostly filter beats and valid coefficient writes, with a little noise mixed in.
	function automatic eq_step_t random_step();
		eq_step_t s;
		int       pick;
		s = '0;
		pick = $urandom_range(99);
		s.ch = 1'($urandom_range(1));
		s.band = BAND_BITS'($urandom_range(BAND_TOP));
		s.sel = SEL_BITS'($urandom_range(SEL_TOP));
		s.coef = COEF_BITS'($urandom);
		s.smp = $urandom;
		if (pick < 70) begin
			s.act = ACT_FILTER;
			case ($urandom_range(9))
			0: s.smp = SAMPLE_MAX;
			1: s.smp = SAMPLE_MIN;
			2, 3, 4: begin
			end
			default: s.smp = SAMPLE_BITS'($urandom_range(65535) - 32768);
			endcase
		end else if (pick < 95) begin
			s.act = ACT_WRITE;
			if ($urandom_range(7) != 0) begin
				s.band = BAND_BITS'($urandom_range(NUM_BANDS - 1));
				s.sel = SEL_BITS'($urandom_range(COEFS_PER_BAND - 1));
			end
			case ($urandom_range(9))
			0: s.coef = COEF_BITS'($urandom_range(1) ? COEF_MAX : COEF_MIN);
			1, 2: begin
			end
			3: begin
				// Rewrite the stored value: must leave history alone
				if (s.band < NUM_BANDS && s.sel < COEFS_PER_BAND)
					s.coef = coef_bank[((s.ch ? NUM_BANDS : 0) + s.band) * COEFS_PER_BAND
						+ s.sel];
			end
			4: s.coef = COEF_BITS'(COEF_ONE + $urandom_range(COEF_HALF / 2) - COEF_HALF / 4);
			default: s.coef = COEF_BITS'($urandom_range(COEF_ONE) - COEF_HALF);
			endcase
		end else if (pick < 98) begin
			s.act = ACT_CLEAR;
		end else begin
			s.act = ACT_NONE;
		end
		return s;
	endfunction

	initial begin : stimulus
		eq_step_t             s;
		logic [MASK_BITS-1:0] mask;
		int                   phase;
		int                   count;
		int                   i;

		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		item_ch.valid = 1'b0;
		item_ch.action = ACT_FILTER;
		item_ch.channel = CH_LEFT;
		item_ch.band = '0;
		item_ch.coef_select = SEL_A0;
		item_ch.coef_value = '0;
		item_ch.sample_in = '0;
		band_mask = MASK_NONE;
		for (i = 0; i < COEF_DEPTH; i++)
			coef_bank[i] = '0;
		for (i = 0; i < BANK_SIZE; i++)
			clear_hist(i);

		// Directed rows. With the mask at its reset value every band is bypassed.
		directed_rows.push_back(row(0, ACT_FILTER, CH_LEFT, 0, SEL_A0, 0, SAMPLE_MAX,
			1, SAMPLE_MAX, 0));
		directed_rows.push_back(row(0, ACT_FILTER, CH_RIGHT, 0, SEL_A0, 0, SAMPLE_MIN,
			1, SAMPLE_MIN, 0));
		directed_rows.push_back(row(0, ACT_FILTER, CH_LEFT, 0, SEL_A0, 0, 0, 1, 0, 0));
		directed_rows.push_back(row(0, ACT_WRITE, CH_LEFT, 0, SEL_A0, COEF_ONE, 0, 0, 0, 0));
		// Band or select past the end: dropped
		directed_rows.push_back(row(0, ACT_WRITE, CH_LEFT, BAND_PAST_END, SEL_A0, 12345, 0,
			0, 0, 0));
		directed_rows.push_back(row(0, ACT_WRITE, CH_RIGHT, BAND_TOP, SEL_B2, COEF_MIN, 0,
			0, 0, 0));
		directed_rows.push_back(row(0, ACT_WRITE, CH_LEFT, 0, SEL_PAST_END, COEF_MAX, 0,
			0, 0, 0));
		directed_rows.push_back(row(0, ACT_WRITE, CH_RIGHT, 5, SEL_TOP, -1, 0, 0, 0, 0));
		// Unused action: no output beat
		directed_rows.push_back(row(0, ACT_NONE, CH_RIGHT, BAND_TOP, SEL_TOP, -1, -1,
			0, 0, 0));
		directed_rows.push_back(row(1, ACT_NONE, CH_LEFT, 0, SEL_A0, 0, MASK_FIRST, 0, 0, 0));
		// Left band 0 at unity gain; right band 0 active with all-zero coefficients
		directed_rows.push_back(row(0, ACT_FILTER, CH_LEFT, 0, SEL_A0, 0, 12345,
			1, 12345, 0));
		directed_rows.push_back(row(0, ACT_FILTER, CH_RIGHT, 0, SEL_A0, 0, -777, 1, 0, 0));
		// Same value again: history must survive
		directed_rows.push_back(row(0, ACT_WRITE, CH_LEFT, 0, SEL_A0, COEF_ONE, 0, 0, 0, 0));
		directed_rows.push_back(row(0, ACT_WRITE, CH_LEFT, 0, SEL_A0, COEF_MAX, 0, 0, 0, 0));
		directed_rows.push_back(row(0, ACT_FILTER, CH_LEFT, 0, SEL_A0, 0, SAMPLE_MAX,
			1, SAMPLE_MAX, 1));
		directed_rows.push_back(row(0, ACT_FILTER, CH_LEFT, 0, SEL_A0, 0, SAMPLE_MIN,
			1, SAMPLE_MIN, 1));
		directed_rows.push_back(row(0, ACT_WRITE, CH_LEFT, 0, SEL_A0, COEF_MIN, 0, 0, 0, 0));
		directed_rows.push_back(row(0, ACT_FILTER, CH_LEFT, 0, SEL_A0, 0, SAMPLE_MAX,
			1, SAMPLE_MIN, 1));
		directed_rows.push_back(row(0, ACT_FILTER, CH_LEFT, 0, SEL_A0, 0, SAMPLE_MIN,
			1, SAMPLE_MAX, 1));
		// Gain one half: exact halves round up
		directed_rows.push_back(row(0, ACT_WRITE, CH_LEFT, 0, SEL_A0, COEF_HALF, 0, 0, 0, 0));
		directed_rows.push_back(row(0, ACT_FILTER, CH_LEFT, 0, SEL_A0, 0, 1, 1, 1, 0));
		directed_rows.push_back(row(0, ACT_FILTER, CH_LEFT, 0, SEL_A0, 0, -1, 1, 0, 0));
		// Feedback and feedforward taps, then a clear in the middle
		directed_rows.push_back(row(0, ACT_WRITE, CH_LEFT, 0, SEL_B1, 3 * COEF_ONE / 4, 0,
			0, 0, 0));
		directed_rows.push_back(row(0, ACT_WRITE, CH_LEFT, 0, SEL_A1, COEF_ONE / 4, 0,
			0, 0, 0));
		directed_rows.push_back(row(0, ACT_FILTER, CH_LEFT, 0, SEL_A0, 0, 1000, 0, 0, 0));
		directed_rows.push_back(row(0, ACT_FILTER, CH_LEFT, 0, SEL_A0, 0, -5000, 0, 0, 0));
		directed_rows.push_back(row(0, ACT_CLEAR, CH_LEFT, 0, SEL_A0, 0, 0, 0, 0, 0));
		directed_rows.push_back(row(0, ACT_FILTER, CH_LEFT, 0, SEL_A0, 0, 300, 0, 0, 0));
		directed_rows.push_back(row(0, ACT_WRITE, CH_RIGHT, 0, SEL_A0, -COEF_HALF, 0,
			0, 0, 0));
		directed_rows.push_back(row(0, ACT_FILTER, CH_RIGHT, 0, SEL_A0, 0, 777, 0, 0, 0));

		// Hold reset, then release it clear of the rising edge
		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		foreach (directed_rows[i])
			send_step(directed_rows[i]);

		// Random phases: rotate through the idle patterns and several masks
		for (phase = 0; phase < NUM_PHASES; phase++) begin
			case (phase % 4)
			0: begin
				idle_pct = 0;
				stall_pct = 0;
			end
			1: begin
				idle_pct = 49;
				stall_pct = 0;
			end
			2: begin
				idle_pct = 0;
				stall_pct = 49;
			end
			default: begin
				idle_pct = 21;
				stall_pct = 21;
			end
			endcase
			case (phase)
			0: mask = MASK_ALL;
			2: mask = MASK_NONE;
			3: mask = MASK_LEFT;
			4: mask = MASK_RIGHT;
			7: mask = MASK_ALL;
			default: mask = MASK_BITS'($urandom);
			endcase
			load_mask(mask);
			count = 0;
			while (count < PHASE_ITEMS) begin
				s = random_step();
				send_step(s);
				// Count only beats that do something
				if (!(s.act == ACT_NONE || (s.act == ACT_WRITE &&
					(s.band >= NUM_BANDS || s.sel >= COEFS_PER_BAND))))
					count++;
			end
		end

		settle();
		if (errors == 0)
			$display("[biquad_cascade_equalizer_unit] OK");
		else
			$display("[biquad_cascade_equalizer_unit] ERROR");
		$finish;
	end

endmodule
